@@ rtl/core/cfa_pkg.sv @@
package cfa_pkg;

   localparam int NUM_FRAMES_DEF = 64;

   localparam int OWNER_W = 8;
   localparam int PAGE_W  = 16;
   localparam int FRAME_W = 6;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_REF   = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   typedef struct packed {
      logic [OWNER_W-1:0] owner;
      logic [PAGE_W-1:0]  page;
   } entry_type;

endpackage

@@ rtl/core/clock_frame_allocator_unit.sv @@
// Physical frame allocator with second-chance (clock) replacement over NUM_FRAMES frames.
// Allocate requests first take never-used frames in ascending order.
// Once all frames are in use, an allocate walks the clock hand over the frame table,
// one frame per cycle through the table's read port, visiting at most 2 * NUM_FRAMES
// frames. A reference request sets the accessed bit of the frame it names, if that
// number is below NUM_FRAMES. The block takes one item at a time; req_stall is high
// while a sweep runs or while a result waits under rsp_stall. The frame table needs no
// clearing after reset: entries are read only after every frame has been handed out
// and written.
module clock_frame_allocator_unit #(
   parameter int NUM_FRAMES = cfa_pkg::NUM_FRAMES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_type,
   input  logic [cfa_pkg::OWNER_W-1:0] req_owner_id,
   input  logic [cfa_pkg::PAGE_W-1:0]  req_page_num,
   input  logic [cfa_pkg::FRAME_W-1:0] req_ref_frame,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [cfa_pkg::FRAME_W-1:0] rsp_frame_num,
   output logic                        rsp_evicted,
   output logic [cfa_pkg::OWNER_W-1:0] rsp_victim_owner,
   output logic [cfa_pkg::PAGE_W-1:0]  rsp_victim_page
);
   import cfa_pkg::*;

   localparam int FW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
   localparam int CW = $clog2(NUM_FRAMES + 1);
   localparam int SW = $clog2(2 * NUM_FRAMES);
   localparam int RW = (FW > FRAME_W) ? FW : FRAME_W;

   localparam logic [FW-1:0] LAST_FRAME = FW'(NUM_FRAMES - 1);
   localparam logic [SW-1:0] LAST_VISIT = SW'(2 * NUM_FRAMES - 1);
   localparam logic [CW-1:0] ALL_USED   = CW'(NUM_FRAMES);

   function automatic logic [FW-1:0] next_frame(input logic [FW-1:0] f);
      return (f == LAST_FRAME) ? '0 : f + FW'(1);
   endfunction

   function automatic logic [FRAME_W-1:0] frame_out(input logic [FW-1:0] f);
      logic [RW-1:0] e;
      e = RW'(f);
      return e[FRAME_W-1:0];
   endfunction

   state_type          state_ff, state_in;
   logic [FW-1:0]      hand_ff, hand_in;
   logic [CW-1:0]      unused_ff, unused_in;
   logic [SW-1:0]      count_ff, count_in;
   entry_type          op_ff, op_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [FRAME_W-1:0] frame_ff, frame_in;
   logic               evicted_ff, evicted_in;
   logic [OWNER_W-1:0] v_owner_ff, v_owner_in;
   logic [PAGE_W-1:0]  v_page_ff, v_page_in;

   logic               accept;
   logic [RW-1:0]      ref_ext;
   logic               ref_in_range;
   logic [FW-1:0]      fresh_frame;
   logic [FW-1:0]      fallback_frame;

   logic [FW-1:0]      rd_addr;
   entry_type          rd_entry;
   logic               rd_ref;
   logic               ent_we;
   logic [FW-1:0]      ent_addr;
   entry_type          ent_data;
   logic               ref_we;
   logic [FW-1:0]      ref_addr;
   logic               ref_wdata;

   logic               live, take, clear, last;

   assign req_stall    = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept       = req_valid && !req_stall;
   assign ref_ext      = RW'(req_ref_frame);
   assign ref_in_range = 32'(req_ref_frame) < NUM_FRAMES;
   assign fresh_frame  = unused_ff[FW-1:0];
   assign fallback_frame = next_frame(hand_ff);

   assign live  = rd_entry.owner != '0;
   assign take  = live && !rd_ref;
   assign clear = live && rd_ref;
   assign last  = count_ff == LAST_VISIT;

   cfa_table #(
      .NUM_FRAMES (NUM_FRAMES),
      .FW         (FW)
   ) u_table (
      .clock     (clock),
      .rd_addr   (rd_addr),
      .rd_entry  (rd_entry),
      .rd_ref    (rd_ref),
      .ent_we    (ent_we),
      .ent_addr  (ent_addr),
      .ent_data  (ent_data),
      .ref_we    (ref_we),
      .ref_addr  (ref_addr),
      .ref_wdata (ref_wdata)
   );

   always_comb begin
      state_in     = state_ff;
      hand_in      = hand_ff;
      unused_in    = unused_ff;
      count_in     = count_ff;
      op_in        = op_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      frame_in     = frame_ff;
      evicted_in   = evicted_ff;
      v_owner_in   = v_owner_ff;
      v_page_in    = v_page_ff;
      rd_addr      = hand_ff;
      ent_we       = 1'b0;
      ent_addr     = hand_ff;
      ent_data     = op_ff;
      ref_we       = 1'b0;
      ref_addr     = hand_ff;
      ref_wdata    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in = '{owner: req_owner_id, page: req_page_num};
               if (req_type == REQ_REF) begin
                  ref_we       = ref_in_range;
                  ref_addr     = ref_ext[FW-1:0];
                  ref_wdata    = 1'b1;
                  rsp_valid_in = 1'b1;
                  frame_in     = req_ref_frame;
                  evicted_in   = 1'b0;
                  v_owner_in   = '0;
                  v_page_in    = '0;
               end else if (unused_ff < ALL_USED) begin
                  ent_we       = 1'b1;
                  ent_addr     = fresh_frame;
                  ent_data     = '{owner: req_owner_id, page: req_page_num};
                  ref_we       = 1'b1;
                  ref_addr     = fresh_frame;
                  ref_wdata    = 1'b1;
                  unused_in    = unused_ff + CW'(1);
                  rsp_valid_in = 1'b1;
                  frame_in     = frame_out(fresh_frame);
                  evicted_in   = 1'b0;
                  v_owner_in   = '0;
                  v_page_in    = '0;
               end else begin
                  count_in = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            rd_addr  = next_frame(hand_ff);
            hand_in  = next_frame(hand_ff);
            count_in = count_ff + SW'(1);
            if (take) begin
               ent_we       = 1'b1;
               ref_we       = 1'b1;
               ref_wdata    = 1'b1;
               rsp_valid_in = 1'b1;
               frame_in     = frame_out(hand_ff);
               evicted_in   = 1'b1;
               v_owner_in   = rd_entry.owner;
               v_page_in    = rd_entry.page;
               state_in     = ST_IDLE;
            end else if (last) begin
               // no owned frame anywhere: take the frame after the hand, where the sweep began
               ent_we       = 1'b1;
               ent_addr     = fallback_frame;
               ref_we       = 1'b1;
               ref_addr     = fallback_frame;
               ref_wdata    = 1'b1;
               hand_in      = next_frame(fallback_frame);
               rsp_valid_in = 1'b1;
               frame_in     = frame_out(fallback_frame);
               evicted_in   = 1'b0;
               v_owner_in   = '0;
               v_page_in    = '0;
               state_in     = ST_IDLE;
            end else if (clear) begin
               ref_we    = 1'b1;
               ref_wdata = 1'b0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hand_ff      <= '0;
         unused_ff    <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hand_ff      <= hand_in;
         unused_ff    <= unused_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      frame_ff   <= frame_in;
      evicted_ff <= evicted_in;
      v_owner_ff <= v_owner_in;
      v_page_ff  <= v_page_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_num    = frame_ff;
   assign rsp_evicted      = evicted_ff;
   assign rsp_victim_owner = v_owner_ff;
   assign rsp_victim_page  = v_page_ff;

   a_hand_range: assert property (@(posedge clock) disable iff (reset)
      32'(hand_ff) < NUM_FRAMES)
      else $error("clock hand out of range");

   a_unused_range: assert property (@(posedge clock) disable iff (reset)
      unused_ff <= ALL_USED)
      else $error("unused frame count past table size");

   a_scan_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (unused_ff == ALL_USED))
      else $error("sweep started with never-used frames left");

   a_scan_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !rsp_valid_ff)
      else $error("result pending during sweep");

   a_scan_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && last) |=> (state_ff == ST_IDLE && rsp_valid_ff))
      else $error("sweep ran past two turns");

endmodule

@@ rtl/core/cfa_table.sv @@
module cfa_table #(
   parameter int NUM_FRAMES = cfa_pkg::NUM_FRAMES_DEF,
   parameter int FW         = 6
) (
   input  logic                clock,
   input  logic [FW-1:0]       rd_addr,
   output cfa_pkg::entry_type  rd_entry,
   output logic                rd_ref,
   input  logic                ent_we,
   input  logic [FW-1:0]       ent_addr,
   input  cfa_pkg::entry_type  ent_data,
   input  logic                ref_we,
   input  logic [FW-1:0]       ref_addr,
   input  logic                ref_wdata
);
   import cfa_pkg::*;

   entry_type entry_mem [NUM_FRAMES];
   logic      ref_mem   [NUM_FRAMES];

   entry_type rd_entry_ff;
   logic      rd_ref_ff;

   always_ff @(posedge clock) begin
      if (ent_we) begin
         entry_mem[ent_addr] <= ent_data;
      end
      rd_entry_ff <= entry_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (ref_we) begin
         ref_mem[ref_addr] <= ref_wdata;
      end
      rd_ref_ff <= ref_mem[rd_addr];
   end

   assign rd_entry = rd_entry_ff;
   assign rd_ref   = rd_ref_ff;

endmodule
